>>> hw/rtl/bmw_pkg.sv
// Shared types, constants and window functions of the binary morphology window.
`default_nettype none

package bmw_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MASK  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   localparam logic MODE_EROSION  = 1'b0;
   localparam logic MODE_DILATION = 1'b1;

   localparam logic [8:0] WINDOW_MASK_RESET = 9'h1FF;
   localparam logic [8:0] WINDOW_RESET      = 9'h1FF;

   localparam logic [7:0] PIXEL_OBJECT     = 8'd0;
   localparam logic [7:0] PIXEL_BACKGROUND = 8'd255;

   typedef struct packed {
      logic       mode;
      logic [8:0] window_mask;
   } bmw_cfg_type;

   // Per-item position flags, worked out when the item is accepted.
   typedef struct packed {
      logic first_col;
      logic outside;
      logic top_en;
      logic mid_en;
      logic pix_valid;
      logic frame_last;
   } bmw_flags_type;

   // Moves the window one column to the left; col bit i enters the right
   // column of window row i.
   function automatic logic [8:0] shift_window(input logic [8:0] win, input logic [2:0] col);
      logic [8:0] n;
      n    = (win >> 1) & 9'h0DB;
      n[2] = col[0];
      n[5] = col[1];
      n[8] = col[2];
      return n;
   endfunction

   function automatic logic [8:0] reflect_mask(input logic [8:0] m);
      logic [8:0] r;
      for (int k = 0; k < 9; k++) begin
         r[8-k] = m[k];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bmw_csr.sv
// Configuration registers, with frame sizes clamped to the supported range on write.
`default_nettype none

module bmw_csr #(
   parameter int MAX_WIDTH  = bmw_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [bmw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bmw_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output bmw_pkg::bmw_cfg_type                    cfg,
   output logic [$clog2(MAX_WIDTH):0]              frame_w,
   output logic [$clog2(MAX_HEIGHT+3)-1:0]         frame_h
);

   localparam int WW = $clog2(MAX_WIDTH) + 1;
   localparam int RW = $clog2(MAX_HEIGHT + 3);
   localparam int W_RESET = (bmw_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                            MAX_WIDTH : bmw_pkg::FRAME_WIDTH_RESET;
   localparam int H_RESET = (bmw_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                            MAX_HEIGHT : bmw_pkg::FRAME_HEIGHT_RESET;

   bmw_pkg::bmw_cfg_type cfg_ff;
   logic [WW-1:0]        frame_w_ff;
   logic [RW-1:0]        frame_h_ff;
   logic [WW-1:0]        w_clamped;
   logic [RW-1:0]        h_clamped;

   // A size of zero counts as one; anything above the maximum saturates.
   always_comb begin
      if (csr_wr_data == '0) begin
         w_clamped = WW'(1);
         h_clamped = RW'(1);
      end else begin
         if (32'(csr_wr_data) > 32'(MAX_WIDTH)) begin
            w_clamped = WW'(MAX_WIDTH);
         end else begin
            w_clamped = WW'(csr_wr_data);
         end
         if (32'(csr_wr_data) > 32'(MAX_HEIGHT)) begin
            h_clamped = RW'(MAX_HEIGHT);
         end else begin
            h_clamped = RW'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= bmw_pkg::MODE_EROSION;
         cfg_ff.window_mask <= bmw_pkg::WINDOW_MASK_RESET;
         frame_w_ff         <= WW'(W_RESET);
         frame_h_ff         <= RW'(H_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bmw_pkg::CSR_MODE:         cfg_ff.mode        <= csr_wr_data[0];
            bmw_pkg::CSR_WINDOW_MASK:  cfg_ff.window_mask <= csr_wr_data[8:0];
            bmw_pkg::CSR_FRAME_WIDTH:  frame_w_ff         <= w_clamped;
            bmw_pkg::CSR_FRAME_HEIGHT: frame_h_ff         <= h_clamped;
            default: ;
         endcase
      end
   end

   assign cfg     = cfg_ff;
   assign frame_w = frame_w_ff;
   assign frame_h = frame_h_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bmw_scan.sv
// Raster position counters and the per-item position flags.
`default_nettype none

module bmw_scan #(
   parameter int MAX_WIDTH  = bmw_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic [$clog2(MAX_WIDTH):0]         frame_w,
   input  wire logic [$clog2(MAX_HEIGHT+3)-1:0]    frame_h,
   output logic [$clog2(MAX_WIDTH)-1:0]            column,
   output bmw_pkg::bmw_flags_type                  flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT + 3);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] c_a, c;
   logic [RW-1:0] r_a, r;
   logic [RW-1:0] h1, h2;
   logic [WW-1:0] c_inc;

   always_comb begin
      h1 = frame_h + RW'(1);
      h2 = frame_h + RW'(2);

      // A column left past the width by a size change wraps to the next row,
      // and a row past the flush row restarts the frame.
      if ({1'b0, col_ff} >= frame_w) begin
         c_a = '0;
         r_a = row_ff + RW'(1);
      end else begin
         c_a = col_ff;
         r_a = row_ff;
      end
      if (r_a > h1) begin
         c = '0;
         r = '0;
      end else begin
         c = c_a;
         r = r_a;
      end

      flags.first_col  = (c == '0);
      flags.outside    = (r >= frame_h);
      flags.top_en     = (r >= RW'(2)) && (r < h2);
      flags.mid_en     = (r >= RW'(1)) && (r <= frame_h);
      flags.pix_valid  = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
      flags.frame_last = flags.pix_valid && (r == h1) && (c == '0);

      c_inc = {1'b0, c} + WW'(1);
      if (flags.frame_last) begin
         col_in = '0;
         row_in = '0;
      end else if (c_inc >= frame_w) begin
         col_in = '0;
         row_in = r + RW'(1);
      end else begin
         col_in = c_inc[CW-1:0];
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign column = c;

endmodule

`default_nettype wire

>>> hw/rtl/bmw_line_store.sv
// Two one-bit line memories with registered read and write-to-read forwarding.
`default_nettype none

module bmw_line_store #(
   parameter int MAX_WIDTH = bmw_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   input  wire logic                           wr_upper,
   input  wire logic                           wr_lower,
   output logic                                rd_upper,
   output logic                                rd_lower
);

   logic upper_store_ff [MAX_WIDTH];
   logic lower_store_ff [MAX_WIDTH];
   logic rd_upper_ff;
   logic rd_lower_ff;
   logic forward;

   // The item leaving the window stage writes the entry that the next item
   // reads when the row is a single pixel wide.
   assign forward = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_store_ff[wr_addr] <= wr_upper;
         lower_store_ff[wr_addr] <= wr_lower;
      end
      if (rd_en) begin
         rd_upper_ff <= forward ? wr_upper : upper_store_ff[rd_addr];
         rd_lower_ff <= forward ? wr_lower : lower_store_ff[rd_addr];
      end
   end

   assign rd_upper = rd_upper_ff;
   assign rd_lower = rd_lower_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bmw_window.sv
// The 3x3 window register and the erosion and dilation decision.
`default_nettype none

module bmw_window (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire bmw_pkg::bmw_flags_type flags,
   input  wire logic                   newbit,
   input  wire logic                   rd_upper,
   input  wire logic                   rd_lower,
   input  wire bmw_pkg::bmw_cfg_type   cfg,
   output logic                        zero_out
);

   logic [8:0] window_ff, window_in;
   logic [8:0] eval;
   logic [2:0] col;
   logic       top, mid;

   always_comb begin
      // Rows outside the frame read as background.
      top = flags.top_en ? rd_upper : 1'b1;
      mid = flags.mid_en ? rd_lower : 1'b1;
      col = {newbit, mid, top};

      // At the start of a row the centre ends the previous row: its right column lies outside the frame.
      if (flags.first_col) begin
         eval      = bmw_pkg::shift_window(window_ff, 3'b111);
         window_in = bmw_pkg::shift_window(eval, col);
      end else begin
         window_in = bmw_pkg::shift_window(window_ff, col);
         eval      = window_in;
      end

      if (cfg.mode == bmw_pkg::MODE_EROSION) begin
         zero_out = (eval & cfg.window_mask) == 9'd0;
      end else begin
         zero_out = ((~eval) & bmw_pkg::reflect_mask(cfg.window_mask)) != 9'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= bmw_pkg::WINDOW_RESET;
      end else if (fire) begin
         window_ff <= window_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/binary_morphology_window.sv
// Top level of the streaming 3x3 binary erosion and dilation block.
//
//   Channel  Direction  Ports                              Contents
//   req      in         req_tvalid/tready/tdata/tuser      pixel_value, pad
//   rsp      out        rsp_tvalid/tready/tdata/tuser/tlast out_pixel, out_valid, frame_last
//   csr      in         csr_wr_en/csr_index/csr_wr_data    mode, window_mask, frame sizes
//
// One item is taken every cycle while the window stage is empty or moving on;
// an accepted item enters the window stage register, and the line memories are
// read on acceptance; a moving window stage updates the window and loads the result.
// In stream terms a pixel's result leaves frame_width+1 items after it enters.
// Reset is synchronous; line memories need no clearing pass.
// A stalled result holds the window stage, and the input takes a new item only
// while the window stage is empty or moving on.
`default_nettype none

module binary_morphology_window #(
   parameter int MAX_WIDTH  = bmw_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] pixel_value
   input  wire logic                            req_tuser,   // [0] pad
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] out_pixel
   output logic                                 rsp_tuser,   // [0] out_valid
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wr_en,
   input  wire logic [bmw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bmw_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT + 3);

   bmw_pkg::bmw_cfg_type   cfg;
   logic [WW-1:0]          frame_w;
   logic [RW-1:0]          frame_h;
   logic [CW-1:0]          column;
   bmw_pkg::bmw_flags_type flags;

   logic                   req_accept;
   logic                   s1_fire;
   logic                   s1_valid_ff, s1_valid_in;
   bmw_pkg::bmw_flags_type s1_flags_ff;
   logic                   s1_newbit_ff, newbit_in;
   logic [CW-1:0]          s1_col_ff;
   logic                   rd_upper, rd_lower;
   logic                   zero_out;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_user_ff;
   logic                   rsp_last_ff;

   bmw_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg),
      .frame_w     (frame_w),
      .frame_h     (frame_h)
   );

   bmw_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .frame_w (frame_w),
      .frame_h (frame_h),
      .column  (column),
      .flags   (flags)
   );

   bmw_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (req_accept),
      .rd_addr  (column),
      .wr_en    (s1_fire),
      .wr_addr  (s1_col_ff),
      .wr_upper (rd_lower),
      .wr_lower (s1_newbit_ff),
      .rd_upper (rd_upper),
      .rd_lower (rd_lower)
   );

   bmw_window u_window (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .flags    (s1_flags_ff),
      .newbit   (s1_newbit_ff),
      .rd_upper (rd_upper),
      .rd_lower (rd_lower),
      .cfg      (cfg),
      .zero_out (zero_out)
   );

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   // Pad items and rows below the frame enter the line memory as background.
   assign newbit_in = req_tuser || flags.outside || (req_tdata != 8'd0);

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (s1_flags_ff.pix_valid && !zero_out) begin
         rsp_pixel_in = bmw_pkg::PIXEL_BACKGROUND;
      end else begin
         rsp_pixel_in = bmw_pkg::PIXEL_OBJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flags_ff  <= flags;
         s1_newbit_ff <= newbit_in;
         s1_col_ff    <= column;
      end
      if (s1_fire) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_user_ff  <= s1_flags_ff.pix_valid;
         rsp_last_ff  <= s1_flags_ff.frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_last_is_valid : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("frame end marked on a result outside the frame");

   a_pixel_binary : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == bmw_pkg::PIXEL_OBJECT ||
                      rsp_tdata == bmw_pkg::PIXEL_BACKGROUND))
      else $error("result pixel is neither object nor background");

   a_invalid_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == bmw_pkg::PIXEL_OBJECT))
      else $error("result outside the frame carries a nonzero pixel");

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item did not reach the window stage");

endmodule

`default_nettype wire

>>> verif/tb_binary_morphology_window.sv
// Self-checking testbench for the streaming 3x3 binary erosion and dilation block.
`default_nettype none

typedef struct packed {
   logic [7:0] pixel;
   logic       valid;
   logic       last;
} morph_result_type;

// Tracks the frame position, line stores and window of the block and holds the
// results still owed for items already taken.
class morph_scoreboard;
   logic             mode;
   logic [8:0]       window_mask;
   logic [10:0]      frame_width;
   logic [10:0]      frame_height;
   logic             upper_line [bmw_pkg::MAX_WIDTH_DEFAULT];
   logic             lower_line [bmw_pkg::MAX_WIDTH_DEFAULT];
   logic [8:0]       window;
   int unsigned      col_pos;
   int unsigned      row_pos;
   morph_result_type expected_results [$];
   int unsigned      results_seen;
   int unsigned      failures;

   function new();
      mode         = bmw_pkg::MODE_EROSION;
      window_mask  = bmw_pkg::WINDOW_MASK_RESET;
      frame_width  = 11'(bmw_pkg::FRAME_WIDTH_RESET);
      frame_height = 11'(bmw_pkg::FRAME_HEIGHT_RESET);
      window       = bmw_pkg::WINDOW_RESET;
      col_pos      = 0;
      row_pos      = 0;
      results_seen = 0;
      failures     = 0;
   endfunction

   function int unsigned clamp_dim(logic [10:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function int unsigned active_width();
      return clamp_dim(frame_width, bmw_pkg::MAX_WIDTH_DEFAULT);
   endfunction

   function int unsigned active_height();
      return clamp_dim(frame_height, bmw_pkg::MAX_HEIGHT_DEFAULT);
   endfunction

   // Each window row moves one column left and takes a new pixel on the right.
   function logic [8:0] slide(logic [8:0] w, logic [2:0] entering);
      return {entering[2], w[8:7], entering[1], w[5:4], entering[0], w[2:1]};
   endfunction

   function void write_reg(logic [bmw_pkg::CSR_INDEX_W-1:0] index,
                           logic [bmw_pkg::CSR_DATA_W-1:0] value);
      case (index)
         bmw_pkg::CSR_MODE:         mode = value[0];
         bmw_pkg::CSR_WINDOW_MASK:  window_mask = value[8:0];
         bmw_pkg::CSR_FRAME_WIDTH:  frame_width = value;
         bmw_pkg::CSR_FRAME_HEIGHT: frame_height = value;
         default: ;
      endcase
   endfunction

   function void note_input(logic [7:0] pixel, logic pad);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int               k;
      logic             fresh;
      logic             top;
      logic             mid;
      logic             dark;
      logic             valid;
      logic             last;
      logic [8:0]       view;
      logic [8:0]       mirrored;
      morph_result_type want;
      w = active_width();
      h = active_height();
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > h + 1) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      // A stored 1 stands for background as well as for anything outside the frame.
      fresh = (pad || r >= h) ? 1'b1 : (pixel != bmw_pkg::PIXEL_OBJECT);
      top = (r >= 2 && r - 2 < h) ? upper_line[c] : 1'b1;
      mid = (r >= 1 && r - 1 < h) ? lower_line[c] : 1'b1;
      upper_line[c] = lower_line[c];
      lower_line[c] = fresh;
      if (c == 0) begin
         // The centre sits at the end of the previous row: its right column is outside.
         view = slide(window, 3'b111);
         window = slide(view, {fresh, mid, top});
      end else begin
         window = slide(window, {fresh, mid, top});
         view = window;
      end
      for (k = 0; k < 9; k++) begin
         mirrored[k] = window_mask[8-k];
      end
      if (mode == bmw_pkg::MODE_EROSION)
         dark = (view & window_mask) == 9'd0;
      else
         dark = (~view & mirrored) != 9'd0;
      valid = r >= 2 || (r == 1 && c >= 1);
      last = valid && r == h + 1 && c == 0;
      want.pixel = (valid && !dark) ? bmw_pkg::PIXEL_BACKGROUND : bmw_pkg::PIXEL_OBJECT;
      want.valid = valid;
      want.last = last;
      expected_results = {expected_results, want};
      if (last) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
      end
   endfunction

   function void check_result(logic [7:0] pixel, logic valid, logic last);
      morph_result_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("result %0d arrived with no item waiting for it", results_seen);
         return;
      end
      want = expected_results.pop_front();
      if (want.pixel !== pixel || want.valid !== valid || want.last !== last) begin
         failures++;
         if (failures <= 10)
            $display("result %0d: expected pixel %0d valid %0d last %0d, got %0d %0d %0d",
                     results_seen, want.pixel, want.valid, want.last, pixel, valid, last);
      end
   endfunction
endclass

module tb_binary_morphology_window;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 1000;
   localparam int ITEM_TARGET = 1100;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_wr_en;
   logic [bmw_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bmw_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   morph_scoreboard sb;
   bit              steady;
   int unsigned     items_sent;
   int unsigned     quiet_cycles;

   binary_morphology_window dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Both channels are sampled here at the rising edge; stimulus moves at the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : result_sink
      int unsigned stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(3);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_pixel(input logic [7:0] pixel, input logic pad);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(3);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = pixel;
      req_tuser = pad;
      items_sent++;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic await_results();
      req_tvalid = 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bmw_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bmw_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wr_data = value;
      sb.write_reg(index, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Geometry only changes between frames, so every line store entry is written before use.
   task automatic configure(input logic m, input logic [8:0] mask,
                            input logic [10:0] width, input logic [10:0] height);
      await_results();
      repeat (4) @(negedge clock);
      write_csr(bmw_pkg::CSR_MODE, bmw_pkg::CSR_DATA_W'(m));
      write_csr(bmw_pkg::CSR_WINDOW_MASK, bmw_pkg::CSR_DATA_W'(mask));
      write_csr(bmw_pkg::CSR_FRAME_WIDTH, width);
      write_csr(bmw_pkg::CSR_FRAME_HEIGHT, height);
   endtask

   // One frame of random blobs, then one row and one item of flush to bring out frame_last.
   task automatic stream_frame(input int unsigned density);
      int unsigned n;
      logic [7:0]  value;
      for (n = 0; n < sb.active_width() * sb.active_height(); n++) begin
         value = ($urandom_range(99) < density) ? bmw_pkg::PIXEL_OBJECT
                                                : 8'($urandom_range(255, 1));
         send_pixel(value, $urandom_range(49) == 0);
      end
      for (n = 0; n <= sb.active_width(); n++)
         send_pixel(8'($urandom_range(255)), $urandom_range(7) != 0);
   endtask

   function automatic logic [8:0] pick_mask();
      case ($urandom_range(4))
         0:       return 9'h000;
         1:       return bmw_pkg::WINDOW_MASK_RESET;
         2:       return 9'(1 << $urandom_range(8));
         default: return 9'($urandom_range(511));
      endcase
   endfunction

   function automatic logic [10:0] pick_size();
      case ($urandom_range(9))
         0:       return 11'd0;
         1:       return 11'($urandom_range(20, 9));
         default: return 11'($urandom_range(8, 1));
      endcase
   endfunction

   function automatic logic pick_mode();
      return ($urandom_range(1) == 0) ? bmw_pkg::MODE_EROSION : bmw_pkg::MODE_DILATION;
   endfunction

   initial begin : stimulus
      logic [7:0]  probe [9];
      int unsigned frames;
      int unsigned j;
      int          i;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = bmw_pkg::CSR_MODE;
      csr_wr_data = '0;
      steady = 1'b0;
      items_sent = 0;
      quiet_cycles = 0;
      probe = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128, 8'd0, 8'd0, 8'd64};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Small frame with field extremes and a pad item inside the frame; the sender
      // holds off mid-frame until every owed result is out.
      configure(bmw_pkg::MODE_EROSION, bmw_pkg::WINDOW_MASK_RESET, 11'd3, 11'd3);
      for (i = 0; i < 9; i++) begin
         if (i == 5) await_results();
         send_pixel(probe[i], i == 7);
      end
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h55, 1'b1);
      send_pixel(8'hAA, 1'b0);

      // Zero sizes count as one; an empty mask forces object in erosion, background
      // in dilation.
      configure(bmw_pkg::MODE_EROSION, 9'h000, 11'd0, 11'd0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd0, 1'b0);
      configure(bmw_pkg::MODE_DILATION, 9'h000, 11'd0, 11'd0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd3, 1'b1);
      send_pixel(8'd9, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         steady = $urandom_range(3) == 0;
         configure(pick_mode(), pick_mask(), pick_size(), pick_size());
         frames = $urandom_range(3, 1);
         for (j = 0; j < frames && items_sent < ITEM_TARGET; j++)
            stream_frame($urandom_range(100));
      end
      steady = 1'b0;

      await_results();
      repeat (8) @(negedge clock);
      if (sb.failures == 0 && sb.expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
